/* design/assert_macros.svh */
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GPF_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define GPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/gpf_pkg.sv */
package gpf_pkg;

  localparam int NAX    = 3;    // spatial axes
  localparam int POS_W  = 32;   // Q16.16 position / force / mass
  localparam int MAG_W  = 33;   // |a - b| per axis
  localparam int SQ_W   = 66;   // sum of squares
  localparam int ROOT_W = 34;   // integer square root of the sum
  localparam int SQT_W  = 70;   // square root remainder and trial width
  localparam int PROD_W = 64;   // 32x32 products
  localparam int NUM_W  = 128;  // G*ma*mb*|d|
  localparam int SRL_W  = 66;   // sum[31:0] * root
  localparam int SRH_W  = 68;   // sum[65:32] * root
  localparam int SR_W   = 100;  // sum * root
  localparam int DEN_W  = 116;  // sum * root * 2^16
  localparam int Q_W    = 31;   // quotient bits below saturation
  localparam int CMP_W  = DEN_W + Q_W;

  localparam logic [POS_W-1:0] GRAV_RESET = 32'd42950;
  localparam logic [POS_W-1:0] QMAX       = {1'b0, {Q_W{1'b1}}};

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [POS_W-1:0] word_t;

  // One pair on its way through the front end, the root stages and the divider stages.
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic [NAX-1:0]     pos;
    logic [NAX-1:0]     neg;
    num_t [NAX-1:0]     num;
  } item_t;

  // One finished transaction.
  typedef struct packed {
    logic               vld;
    logic               coincident;
    logic               saturated;
    word_t [NAX-1:0]    fa;
    word_t [NAX-1:0]    fb;
  } res_t;

endpackage

/* design/gpf_front.sv */
module gpf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [31:0]           a_pos_x,
  input  logic signed [31:0]           a_pos_y,
  input  logic signed [31:0]           a_pos_z,
  input  logic signed [31:0]           b_pos_x,
  input  logic signed [31:0]           b_pos_y,
  input  logic signed [31:0]           b_pos_z,
  input  logic [31:0]                  a_mass,
  input  logic [31:0]                  b_mass,
  input  logic [31:0]                  grav,
  output gpf_pkg::item_t               item_o,
  output logic [gpf_pkg::SQ_W-1:0]     sum_o
);

  logic [gpf_pkg::MAG_W-1:0] dlt [gpf_pkg::NAX];

  logic                          v1_r, v2_r, v3_r;
  logic [gpf_pkg::NAX-1:0]       pos1_r, neg1_r, pos2_r, neg2_r, pos3_r, neg3_r;
  logic [gpf_pkg::MAG_W-1:0]     mag1_r [gpf_pkg::NAX];
  logic [gpf_pkg::PROD_W-1:0]    gm1_r, gm2_r;
  logic [gpf_pkg::POS_W-1:0]     mb1_r;
  logic [gpf_pkg::SQ_W-1:0]      sq2_r [gpf_pkg::NAX];
  logic [gpf_pkg::PROD_W-1:0]    mm2_r [gpf_pkg::NAX];
  logic                          zero2_r, zero3_r;
  logic [gpf_pkg::SQ_W-1:0]      sum3_r, sum4_r;
  logic [gpf_pkg::PROD_W-1:0]    pp3_r [gpf_pkg::NAX][4];
  gpf_pkg::item_t                item4_r;

  always_comb begin
    dlt[0] = {a_pos_x[31], a_pos_x} - {b_pos_x[31], b_pos_x};
    dlt[1] = {a_pos_y[31], a_pos_y} - {b_pos_y[31], b_pos_y};
    dlt[2] = {a_pos_z[31], a_pos_z} - {b_pos_z[31], b_pos_z};
  end

  // Stage 1: differences, magnitudes and G*ma.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      gm1_r <= grav * a_mass;
      mb1_r <= b_mass;
      for (int i = 0; i < gpf_pkg::NAX; i++) begin
        neg1_r[i] <= dlt[i][gpf_pkg::MAG_W-1];
        pos1_r[i] <= !dlt[i][gpf_pkg::MAG_W-1] && (dlt[i] != '0);
        mag1_r[i] <= dlt[i][gpf_pkg::MAG_W-1] ? gpf_pkg::MAG_W'(0) - dlt[i] : dlt[i];
      end
    end
  end

  // Stage 2: squares and mb*|d| (|d| never exceeds 2^32-1).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r    <= v1_r;
      pos2_r  <= pos1_r;
      neg2_r  <= neg1_r;
      gm2_r   <= gm1_r;
      zero2_r <= (mag1_r[0] == '0) && (mag1_r[1] == '0) && (mag1_r[2] == '0);
      for (int i = 0; i < gpf_pkg::NAX; i++) begin
        sq2_r[i] <= mag1_r[i] * mag1_r[i];
        mm2_r[i] <= mb1_r * mag1_r[i][gpf_pkg::POS_W-1:0];
      end
    end
  end

  // Stage 3: sum of squares and 32x32 partial products of the numerator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r    <= v2_r;
      pos3_r  <= pos2_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      sum3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      for (int i = 0; i < gpf_pkg::NAX; i++) begin
        pp3_r[i][0] <= gm2_r[31:0]  * mm2_r[i][31:0];
        pp3_r[i][1] <= gm2_r[31:0]  * mm2_r[i][63:32];
        pp3_r[i][2] <= gm2_r[63:32] * mm2_r[i][31:0];
        pp3_r[i][3] <= gm2_r[63:32] * mm2_r[i][63:32];
      end
    end
  end

  // Stage 4: merge partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item4_r.vld <= 1'b0;
    end else if (en) begin
      item4_r.vld  <= v3_r;
      item4_r.zero <= zero3_r;
      item4_r.pos  <= pos3_r;
      item4_r.neg  <= neg3_r;
      sum4_r       <= sum3_r;
      for (int i = 0; i < gpf_pkg::NAX; i++) begin
        item4_r.num[i] <= {64'd0, pp3_r[i][0]}
                        + {32'd0, pp3_r[i][1], 32'd0}
                        + {32'd0, pp3_r[i][2], 32'd0}
                        + {pp3_r[i][3], 64'd0};
      end
    end
  end

  assign item_o = item4_r;
  assign sum_o  = sum4_r;

endmodule

/* design/gpf_sqrt.sv */
module gpf_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  gpf_pkg::item_t                item_i,
  input  logic [gpf_pkg::SQ_W-1:0]      sum_i,
  output gpf_pkg::item_t                item_o,
  output logic [gpf_pkg::SQ_W-1:0]      sum_o,
  output logic [gpf_pkg::ROOT_W-1:0]    root_o
);

  gpf_pkg::item_t                 it_r   [gpf_pkg::ROOT_W];
  logic [gpf_pkg::SQT_W-1:0]      rem_r  [gpf_pkg::ROOT_W];
  logic [gpf_pkg::ROOT_W-1:0]     root_r [gpf_pkg::ROOT_W];
  logic [gpf_pkg::SQ_W-1:0]       s_r    [gpf_pkg::ROOT_W];

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < gpf_pkg::ROOT_W; k++) begin : g_stage
    localparam int B = gpf_pkg::ROOT_W - 1 - k;

    gpf_pkg::item_t               it_in;
    logic [gpf_pkg::SQT_W-1:0]    rem_in;
    logic [gpf_pkg::ROOT_W-1:0]   root_in;
    logic [gpf_pkg::SQ_W-1:0]     s_in;
    logic [gpf_pkg::SQT_W-1:0]    trial;
    logic                         take;

    if (k == 0) begin : g_first
      assign it_in   = item_i;
      assign rem_in  = gpf_pkg::SQT_W'(sum_i);
      assign root_in = '0;
      assign s_in    = sum_i;
    end else begin : g_next
      assign it_in   = it_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign s_in    = s_r[k-1];
    end

    assign trial = (gpf_pkg::SQT_W'(root_in) << (B + 1)) | (gpf_pkg::SQT_W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_r[k].vld <= 1'b0;
      end else if (en) begin
        it_r[k]   <= it_in;
        s_r[k]    <= s_in;
        rem_r[k]  <= take ? rem_in - trial : rem_in;
        root_r[k] <= take ? root_in | (gpf_pkg::ROOT_W'(1) << B) : root_in;
      end
    end
  end

  assign item_o = it_r[gpf_pkg::ROOT_W-1];
  assign sum_o  = s_r[gpf_pkg::ROOT_W-1];
  assign root_o = root_r[gpf_pkg::ROOT_W-1];

endmodule

/* design/gpf_div.sv */
module gpf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  gpf_pkg::item_t                item_i,
  input  logic [gpf_pkg::SQ_W-1:0]      sum_i,
  input  logic [gpf_pkg::ROOT_W-1:0]    root_i,
  output gpf_pkg::res_t                 res_o
);

  localparam int QS = gpf_pkg::Q_W;

  gpf_pkg::item_t                 it1_r, it2_r, it3_r;
  logic [gpf_pkg::SRL_W-1:0]      srl1_r;
  logic [gpf_pkg::SRH_W-1:0]      srh1_r;
  logic [gpf_pkg::DEN_W-1:0]      den2_r, den3_r;
  logic [gpf_pkg::SR_W-1:0]       sr_sum;
  logic [gpf_pkg::NAX-1:0]        ovf3_r;

  gpf_pkg::item_t                 itq_r  [QS];
  logic [gpf_pkg::DEN_W-1:0]      denq_r [QS];
  logic [gpf_pkg::NAX-1:0]        ovfq_r [QS];
  logic [gpf_pkg::NUM_W-1:0]      remq_r [QS][gpf_pkg::NAX];
  logic [QS-1:0]                  qq_r   [QS][gpf_pkg::NAX];

  gpf_pkg::res_t                  res_r;

  // Divisor: sum * root * 2^16, in two products and one merge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it1_r.vld <= 1'b0;
      it2_r.vld <= 1'b0;
    end else if (en) begin
      it1_r  <= item_i;
      srl1_r <= sum_i[31:0] * root_i;
      srh1_r <= sum_i[gpf_pkg::SQ_W-1:32] * root_i;
      it2_r  <= it1_r;
      den2_r <= {sr_sum, 16'd0};
    end
  end

  assign sr_sum = {srh1_r, 32'd0} + gpf_pkg::SR_W'(srl1_r);

  // Saturation check: quotient reaches 2^31 when num >= den * 2^31.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it3_r.vld <= 1'b0;
    end else if (en) begin
      it3_r  <= it2_r;
      den3_r <= den2_r;
      for (int i = 0; i < gpf_pkg::NAX; i++) begin
        ovf3_r[i] <= gpf_pkg::CMP_W'(it2_r.num[i]) >= {den2_r, {QS{1'b0}}};
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < QS; j++) begin : g_qbit
    localparam int B = QS - 1 - j;

    gpf_pkg::item_t               it_in;
    logic [gpf_pkg::DEN_W-1:0]    den_in;
    logic [gpf_pkg::NAX-1:0]      ovf_in;
    logic [gpf_pkg::CMP_W-1:0]    dsh;

    if (j == 0) begin : g_first
      assign it_in  = it3_r;
      assign den_in = den3_r;
      assign ovf_in = ovf3_r;
    end else begin : g_next
      assign it_in  = itq_r[j-1];
      assign den_in = denq_r[j-1];
      assign ovf_in = ovfq_r[j-1];
    end

    assign dsh = gpf_pkg::CMP_W'(den_in) << B;

    for (genvar i = 0; i < gpf_pkg::NAX; i++) begin : g_lane
      logic [gpf_pkg::NUM_W-1:0]  rem_in;
      logic [QS-1:0]              q_in;
      logic                       take;

      if (j == 0) begin : g_first
        assign rem_in = it3_r.num[i];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = remq_r[j-1][i];
        assign q_in   = qq_r[j-1][i];
      end

      assign take = gpf_pkg::CMP_W'(rem_in) >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          remq_r[j][i] <= take ? rem_in - dsh[gpf_pkg::NUM_W-1:0] : rem_in;
          qq_r[j][i]   <= take ? q_in | (QS'(1) << B) : q_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        itq_r[j].vld <= 1'b0;
      end else if (en) begin
        itq_r[j]  <= it_in;
        denq_r[j] <= den_in;
        ovfq_r[j] <= ovf_in;
      end
    end
  end

  // Output register: clamp, apply sign, mirror for body B.
  always_ff @(posedge clk) begin
    logic [gpf_pkg::POS_W-1:0] m;
    logic [gpf_pkg::POS_W-1:0] fa;
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else if (en) begin
      res_r.vld        <= itq_r[QS-1].vld;
      res_r.coincident <= itq_r[QS-1].zero;
      res_r.saturated  <= !itq_r[QS-1].zero && (ovfq_r[QS-1] != '0);
      for (int i = 0; i < gpf_pkg::NAX; i++) begin
        m = ovfq_r[QS-1][i] ? gpf_pkg::QMAX : {1'b0, qq_r[QS-1][i]};
        if (itq_r[QS-1].pos[i]) begin
          fa = gpf_pkg::POS_W'(0) - m;
        end else if (itq_r[QS-1].neg[i]) begin
          fa = m;
        end else begin
          fa = '0;
        end
        res_r.fa[i] <= fa;
        res_r.fb[i] <= gpf_pkg::POS_W'(0) - fa;
      end
    end
  end

  assign res_o = res_r;

endmodule

/* design/pairwise_gravity_force_top.sv */
// Pairwise gravitational force between two bodies, Q16.16 fixed point.
//
// Input channel (in_*): positions and masses of bodies A and B, taken on a
// clock edge where in_valid is high and in_stall is low.
// Result channel (out_*): force on A and on B (exact negation), plus the
// coincident and saturated flags, taken where out_valid is high and
// out_stall is low.
// Config channel (cfg_*): one register, G as unsigned Q0.32, written when
// cfg_valid and cfg_ready are high. cfg_ready is always high; write only
// while no transaction is in flight.
//
// The pipeline has 4 front-end stages, 34 square-root stages (one root
// bit each), 3 divisor stages, 31 quotient stages and the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads G with 42950 (about 1e-5).

`include "assert_macros.svh"

module pairwise_gravity_force_top (
  input  logic                clk,
  input  logic                rst_n,
  // config
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_grav_constant,
  // input transactions
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_a_pos_x,
  input  logic signed [31:0]  in_a_pos_y,
  input  logic signed [31:0]  in_a_pos_z,
  input  logic signed [31:0]  in_b_pos_x,
  input  logic signed [31:0]  in_b_pos_y,
  input  logic signed [31:0]  in_b_pos_z,
  input  logic [31:0]         in_a_mass,
  input  logic [31:0]         in_b_mass,
  // result transactions
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_force_a_x,
  output logic signed [31:0]  out_force_a_y,
  output logic signed [31:0]  out_force_a_z,
  output logic signed [31:0]  out_force_b_x,
  output logic signed [31:0]  out_force_b_y,
  output logic signed [31:0]  out_force_b_z,
  output logic                out_coincident,
  output logic                out_saturated
);

  logic [31:0]                       grav_r;
  logic                              adv;
  gpf_pkg::item_t                    fr_item, sq_item;
  logic [gpf_pkg::SQ_W-1:0]          fr_sum, sq_sum;
  logic [gpf_pkg::ROOT_W-1:0]        sq_root;
  gpf_pkg::res_t                     res;

  // G register; the user is to make writes only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= gpf_pkg::GRAV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grav_r <= cfg_grav_constant;
    end
  end

  assign cfg_ready = 1'b1;

  // Advance every stage unless a finished result is being held back.
  assign adv      = !res.vld || !out_stall;
  assign in_stall = !adv;

  gpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .a_pos_x  (in_a_pos_x),
    .a_pos_y  (in_a_pos_y),
    .a_pos_z  (in_a_pos_z),
    .b_pos_x  (in_b_pos_x),
    .b_pos_y  (in_b_pos_y),
    .b_pos_z  (in_b_pos_z),
    .a_mass   (in_a_mass),
    .b_mass   (in_b_mass),
    .grav     (grav_r),
    .item_o   (fr_item),
    .sum_o    (fr_sum)
  );

  gpf_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .item_i (fr_item),
    .sum_i  (fr_sum),
    .item_o (sq_item),
    .sum_o  (sq_sum),
    .root_o (sq_root)
  );

  gpf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .item_i (sq_item),
    .sum_i  (sq_sum),
    .root_i (sq_root),
    .res_o  (res)
  );

  assign out_valid      = res.vld;
  assign out_force_a_x  = res.fa[0];
  assign out_force_a_y  = res.fa[1];
  assign out_force_a_z  = res.fa[2];
  assign out_force_b_x  = res.fb[0];
  assign out_force_b_y  = res.fb[1];
  assign out_force_b_z  = res.fb[2];
  assign out_coincident = res.coincident;
  assign out_saturated  = res.saturated;

  // Coincident bodies carry no force and never saturate.
  `GPF_ASSERT_NOW(a_coinc_zero, clk, rst_n, !(out_valid && out_coincident) || (out_force_a_x == 32'sd0 && out_force_a_y == 32'sd0 && out_force_a_z == 32'sd0 && !out_saturated), "coincident result with nonzero force")
  // Force on B mirrors force on A.
  `GPF_ASSERT_NOW(a_mirror, clk, rst_n, !out_valid || (32'(out_force_a_x + out_force_b_x) == 32'd0 && 32'(out_force_a_y + out_force_b_y) == 32'd0 && 32'(out_force_a_z + out_force_b_z) == 32'd0), "force on B is not the negation of force on A")
  // A held result must freeze the input side.
  `GPF_ASSERT_NOW(a_hold_input, clk, rst_n, !(out_valid && out_stall) || in_stall, "input accepted while output held")
  // A config write updates G.
  `GPF_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready, grav_r == $past(cfg_grav_constant), "G register not updated")

endmodule
